/* rtl/rpn_pkg.sv */
// Shared types and constants for the RPN stack calculator.
// Stand-alone package: no dependencies.
package rpn_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int WORD_BITS   = 32;
   localparam int IO_BITS     = 32;
   localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
   localparam int STEP_BITS   = $clog2(WORD_BITS);
   localparam int SQRT_STEPS  = (WORD_BITS + 1) / 2;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_APPLY = 2'd1,
      REQ_END   = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_POW  = 3'd4,
      OP_LOG  = 3'd5,
      OP_SQRT = 3'd6,
      OP_SEL  = 3'd7
   } op_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CATCH,
      ST_SETUP,
      ST_DIV,
      ST_SIGN,
      ST_POW,
      ST_LOG,
      ST_SQRT,
      ST_WRITE,
      ST_REPLY
   } state_type;

   function automatic logic [1:0] operand_count(op_code_type op);
      logic [1:0] n;
      unique case (op)
         OP_SQRT: n = 2'd1;
         OP_SEL:  n = 2'd3;
         default: n = 2'd2;
      endcase
      return n;
   endfunction

endpackage

/* rtl/rpn_stack_calculator.sv */
// Top level of the RPN stack calculator: sequencer, operand registers and the
// shared multiply / shift-subtract datapath. Depends on rpn_pkg and rpn_ram.
//
//   Requests enter on req_* with req_valid / req_stall; a request is taken at
//   an edge with req_valid high and req_stall low. req_type selects push,
//   operator or end of line; code 3 is taken and dropped.
//   Only end of line produces a response on rsp_* (rsp_valid / rsp_stall):
//   the line's value and an error flag (value zero on error).
//   A push is done in the idle state. An operator reads each operand from the
//   stack RAM in a fetch and a catch state, then passes a setup state, the loop
//   of the shared multiplier / one-bit divider and a write-back state. The loop
//   is absent for add/sub/mul/select; div gets one quotient bit per step and a
//   sign step, pow a multiply and a square per exponent bit, log one step per
//   power tried, sqrt one result bit per step. An error found at setup skips the
//   loop and write-back; a skipped operator never leaves the idle state. End of
//   line passes fetch, catch and reply, or goes straight to reply on an error.
//   The block stalls requests while an operator or end of line is in work.
//   A waiting response does not block pushes; a stalled response holds the
//   next end of line in its final state until the register frees.
//   Reset empties the stack and clears the line error; no clearing pass.
module rpn_stack_calculator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_number_value,
   input  logic [2:0]  req_operator_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_line_value,
   output logic        rsp_line_error
);

   localparam int W  = rpn_pkg::WORD_BITS;
   localparam int CB = rpn_pkg::CNT_BITS;
   localparam int AB = rpn_pkg::ADDR_BITS;
   localparam int SB = rpn_pkg::STEP_BITS;

   rpn_pkg::state_type   state_ff, state_in;
   logic [CB-1:0]        count_ff, count_in;
   logic                 failed_ff, failed_in;
   logic                 eol_ff, eol_in;
   logic                 ok_ff, ok_in;
   rpn_pkg::op_code_type op_ff, op_in;
   logic [1:0]           need_ff, need_in;
   logic [1:0]           idx_ff, idx_in;
   rpn_pkg::word_type    a_ff, a_in, b_ff, b_in, c_ff, c_in;
   rpn_pkg::word_type    res_ff, res_in, p_ff, p_in, e_ff, e_in, rem_ff, rem_in;
   logic [SB-1:0]        step_ff, step_in;
   logic                 neg_ff, neg_in;
   logic                 phase_ff, phase_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_value_ff, rsp_value_in;
   logic                 rsp_error_ff, rsp_error_in;

   logic                 req_accept;
   rpn_pkg::op_code_type req_op;
   logic [1:0]           req_need;
   logic [CB-1:0]        base;
   logic                 rsp_free;
   rpn_pkg::word_type    mul_x, mul_y, cand, mag_a, mag_b;
   logic [2*W-1:0]       prod, a_wide;
   logic [W:0]           div_sh, div_diff;
   logic                 log_bad;
   logic                 wr_en;
   logic [AB-1:0]        wr_addr, rd_addr;
   rpn_pkg::word_type    wr_data, rd_data;

   rpn_ram #(
      .WIDTH (W),
      .DEPTH (rpn_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != rpn_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_op     = rpn_pkg::op_code_type'(req_operator_code);
   assign req_need   = rpn_pkg::operand_count(req_op);
   assign base       = count_ff - CB'(need_ff);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign mag_a    = a_ff[W-1] ? (W'(0) - a_ff) : a_ff;
   assign mag_b    = b_ff[W-1] ? (W'(0) - b_ff) : b_ff;
   assign cand     = res_ff | (W'(1) << step_ff);
   assign prod     = (2*W)'(mul_x) * (2*W)'(mul_y);
   assign a_wide   = (2*W)'(a_ff);
   assign div_sh   = {rem_ff, e_ff[W-1]};
   assign div_diff = div_sh - {1'b0, p_ff};
   assign log_bad  = (a_ff == '0) || a_ff[W-1] || b_ff[W-1] || (b_ff < W'(2));

   always_comb begin
      unique case (state_ff)
         rpn_pkg::ST_SETUP: begin
            mul_x = a_ff;
            mul_y = b_ff;
         end
         rpn_pkg::ST_POW: begin
            mul_x = phase_ff ? p_ff : res_ff;
            mul_y = p_ff;
         end
         rpn_pkg::ST_LOG: begin
            mul_x = p_ff;
            mul_y = b_ff;
         end
         rpn_pkg::ST_SQRT: begin
            mul_x = cand;
            mul_y = cand;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpn_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_type)
                  rpn_pkg::REQ_APPLY: begin
                     if (!failed_ff && (count_ff >= CB'(req_need))) begin
                        state_in = rpn_pkg::ST_FETCH;
                     end
                  end
                  rpn_pkg::REQ_END: begin
                     if (!failed_ff && (count_ff == CB'(1))) begin
                        state_in = rpn_pkg::ST_FETCH;
                     end else begin
                        state_in = rpn_pkg::ST_REPLY;
                     end
                  end
                  default: state_in = rpn_pkg::ST_IDLE;
               endcase
            end
         end
         rpn_pkg::ST_FETCH: state_in = rpn_pkg::ST_CATCH;
         rpn_pkg::ST_CATCH: begin
            if (idx_ff == (need_ff - 2'd1)) begin
               state_in = eol_ff ? rpn_pkg::ST_REPLY : rpn_pkg::ST_SETUP;
            end else begin
               state_in = rpn_pkg::ST_FETCH;
            end
         end
         rpn_pkg::ST_SETUP: begin
            case (op_ff)
               rpn_pkg::OP_DIV:
                  state_in = (b_ff == '0) ? rpn_pkg::ST_IDLE : rpn_pkg::ST_DIV;
               rpn_pkg::OP_POW: state_in = rpn_pkg::ST_POW;
               rpn_pkg::OP_LOG:
                  state_in = log_bad ? rpn_pkg::ST_IDLE : rpn_pkg::ST_LOG;
               rpn_pkg::OP_SQRT:
                  state_in = a_ff[W-1] ? rpn_pkg::ST_IDLE : rpn_pkg::ST_SQRT;
               default: state_in = rpn_pkg::ST_WRITE;
            endcase
         end
         rpn_pkg::ST_DIV: begin
            if (step_ff == '0) begin
               state_in = rpn_pkg::ST_SIGN;
            end
         end
         rpn_pkg::ST_SIGN: state_in = rpn_pkg::ST_WRITE;
         rpn_pkg::ST_POW: begin
            if (e_ff == '0) begin
               state_in = rpn_pkg::ST_WRITE;
            end
         end
         rpn_pkg::ST_LOG: begin
            if (prod > a_wide) begin
               state_in = rpn_pkg::ST_WRITE;
            end
         end
         rpn_pkg::ST_SQRT: begin
            if (step_ff == '0) begin
               state_in = rpn_pkg::ST_WRITE;
            end
         end
         rpn_pkg::ST_WRITE: state_in = rpn_pkg::ST_IDLE;
         rpn_pkg::ST_REPLY: begin
            if (rsp_free) begin
               state_in = rpn_pkg::ST_IDLE;
            end
         end
         default: state_in = rpn_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      failed_in    = failed_ff;
      eol_in       = eol_ff;
      ok_in        = ok_ff;
      op_in        = op_ff;
      need_in      = need_ff;
      idx_in       = idx_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      res_in       = res_ff;
      p_in         = p_ff;
      e_in         = e_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AB-1:0];
      wr_data      = W'($signed(req_number_value));
      rd_addr      = AB'(base + CB'(idx_ff));

      unique case (state_ff)
         rpn_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in  = req_op;
               idx_in = 2'd0;
               eol_in = (req_type == rpn_pkg::REQ_END);
               case (req_type)
                  rpn_pkg::REQ_PUSH: begin
                     if (!failed_ff) begin
                        if (count_ff >= CB'(rpn_pkg::STACK_DEPTH)) begin
                           failed_in = 1'b1;
                        end else begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CB'(1);
                        end
                     end
                  end
                  rpn_pkg::REQ_APPLY: begin
                     need_in = req_need;
                     if (!failed_ff && (count_ff < CB'(req_need))) begin
                        failed_in = 1'b1;
                     end
                  end
                  rpn_pkg::REQ_END: begin
                     need_in = 2'd1;
                     ok_in   = !failed_ff && (count_ff == CB'(1));
                  end
                  default: ;
               endcase
            end
         end
         rpn_pkg::ST_FETCH: ;
         rpn_pkg::ST_CATCH: begin
            idx_in = idx_ff + 2'd1;
            case (idx_ff)
               2'd0:    a_in = rd_data;
               2'd1:    b_in = rd_data;
               default: c_in = rd_data;
            endcase
         end
         rpn_pkg::ST_SETUP: begin
            case (op_ff)
               rpn_pkg::OP_ADD: res_in = a_ff + b_ff;
               rpn_pkg::OP_SUB: res_in = a_ff - b_ff;
               rpn_pkg::OP_MUL: res_in = prod[W-1:0];
               rpn_pkg::OP_SEL: res_in = (a_ff != '0) ? b_ff : c_ff;
               rpn_pkg::OP_DIV: begin
                  failed_in = (b_ff == '0);
                  rem_in    = '0;
                  e_in      = mag_a;
                  p_in      = mag_b;
                  step_in   = SB'(W - 1);
                  neg_in    = a_ff[W-1] ^ b_ff[W-1];
               end
               rpn_pkg::OP_POW: begin
                  res_in   = W'(1);
                  p_in     = a_ff;
                  e_in     = mag_b;
                  phase_in = 1'b0;
               end
               rpn_pkg::OP_LOG: begin
                  failed_in = log_bad;
                  res_in    = '0;
                  p_in      = W'(1);
               end
               default: begin
                  failed_in = a_ff[W-1];
                  res_in    = '0;
                  step_in   = SB'(rpn_pkg::SQRT_STEPS - 1);
               end
            endcase
         end
         rpn_pkg::ST_DIV: begin
            step_in = step_ff - SB'(1);
            if (!div_diff[W]) begin
               rem_in = div_diff[W-1:0];
               e_in   = {e_ff[W-2:0], 1'b1};
            end else begin
               rem_in = div_sh[W-1:0];
               e_in   = {e_ff[W-2:0], 1'b0};
            end
         end
         rpn_pkg::ST_SIGN: res_in = neg_ff ? (W'(0) - e_ff) : e_ff;
         rpn_pkg::ST_POW: begin
            if (e_ff != '0) begin
               phase_in = !phase_ff;
               if (phase_ff) begin
                  p_in = prod[W-1:0];
                  e_in = e_ff >> 1;
               end else if (e_ff[0]) begin
                  res_in = prod[W-1:0];
               end
            end
         end
         rpn_pkg::ST_LOG: begin
            if (prod <= a_wide) begin
               p_in   = prod[W-1:0];
               res_in = res_ff + W'(1);
            end
         end
         rpn_pkg::ST_SQRT: begin
            step_in = step_ff - SB'(1);
            if (prod <= a_wide) begin
               res_in = cand;
            end
         end
         rpn_pkg::ST_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = base[AB-1:0];
            wr_data  = res_ff;
            count_in = base + CB'(1);
         end
         rpn_pkg::ST_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = ok_ff ? 32'(a_ff) : 32'd0;
               rsp_error_in = !ok_ff;
               count_in     = '0;
               failed_in    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpn_pkg::ST_IDLE;
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eol_ff       <= eol_in;
      ok_ff        <= ok_in;
      op_ff        <= op_in;
      need_ff      <= need_in;
      idx_ff       <= idx_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      res_ff       <= res_in;
      p_ff         <= p_in;
      e_ff         <= e_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      neg_ff       <= neg_in;
      phase_ff     <= phase_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_value = rsp_value_ff;
   assign rsp_line_error = rsp_error_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(rpn_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_new_rsp_clears_line: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (count_ff == '0) && !failed_ff)
      else $error("line state not cleared with response");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff) |-> (rsp_value_ff == 32'd0))
      else $error("error response carries a value");

   a_write_back_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rpn_pkg::ST_WRITE) |=> (count_ff == CB'($past(base) + CB'(1))))
      else $error("write-back count mismatch");

   a_operands_present: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rpn_pkg::ST_FETCH) |-> (count_ff >= CB'(need_ff)))
      else $error("operand fetch on short stack");

endmodule

/* rtl/rpn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
